/* rtl/slt_pkg.sv */
// Shared constants, codes and types for the sorted list table.
package slt_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRY_W    = 16;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    // upper command bit selects list (covers the unused code as well)
    localparam int FUNC_LIST_BIT = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_LISTED   = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_LS_RD,
        S_LS_OUT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] entry;
        logic               last;
    } result_t;

endpackage

/* rtl/sorted_list_table.sv */
// Sorted list table: add, remove and list over an ordered store of DEPTH values.
// Add walks down from the top, moving each larger entry up a slot; remove compares the
// entries held until it finds the value, then pulls later ones down; full add and empty
// list skip the walk. Then the status is offered; list offers each entry in turn.
// A result reaches m_tvalid through the output register; s_tready is high only when idle.
// aresetn (synchronous, active low) empties the table; stored values are not cleared.
module sorted_list_table
    import slt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] value
    input  logic [FUNC_W-1:0]    s_tuser,   // [1:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ENTRY_W-1:0]   m_tdata,   // [15:0] entry
    output logic [STATUS_W-1:0]  m_tuser,   // [2:0] status
    output logic                 m_tlast
);

    mem_req_t              mem_req;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  m_tvalid_reg;
    result_t               out_reg;

    slt_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    slt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_func  (s_tuser),
        .cmd_value (VALUE_BITS'(s_tdata)),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.entry;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

/* rtl/slt_mem.sv */
// Entry store: one write port, one registered read port.
module slt_mem
    import slt_pkg::*;
(
    input  logic                  aclk,
    input  mem_req_t              req,
    output logic [VALUE_BITS-1:0] rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/slt_seq.sv */
// Command sequencer with the shared compare unit that walks the store.
module slt_seq
    import slt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [FUNC_W-1:0]     cmd_func,
    input  logic [VALUE_BITS-1:0] cmd_value,
    output mem_req_t              mem_req,
    input  logic [VALUE_BITS-1:0] mem_rdata,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    status_t               stat_reg, stat_next;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      idx_dec;
    logic                  rd_gt;
    logic                  rd_eq;
    logic                  take;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);
    // the one compare unit, shared by the add and remove walks over the store
    assign rd_gt   = mem_rdata > val_reg;
    assign rd_eq   = mem_rdata == val_reg;
    assign take    = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        stat_next     = stat_reg;
        cmd_ready     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[ADDR_W-1:0];
        mem_req.wdata = val_reg;
        mem_req.raddr = idx_reg[ADDR_W-1:0];
        res_valid     = 1'b0;
        res.status    = stat_reg;
        res.entry     = '0;
        res.last      = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    val_next = cmd_value;
                    if (cmd_func[FUNC_LIST_BIT]) begin
                        idx_next = '0;
                        if (count_reg == '0) begin
                            stat_next  = ST_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_LS_RD;
                        end
                    end else if (cmd_func == FUNC_REMOVE) begin
                        idx_next   = '0;
                        state_next = S_RM_RD;
                    end else if (count_reg == CNT_W'(DEPTH)) begin
                        stat_next  = ST_FULL;
                        state_next = S_RESP;
                    end else begin
                        idx_next   = count_reg;
                        state_next = S_ADD_RD;
                    end
                end
            end
            // add walks down from the top, shifting larger entries up one slot
            S_ADD_RD: begin
                mem_req.raddr = idx_dec[ADDR_W-1:0];
                if (idx_reg == '0) begin
                    mem_req.we = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    stat_next  = ST_ADDED;
                    state_next = S_RESP;
                end else begin
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                mem_req.we = 1'b1;
                if (rd_gt) begin
                    mem_req.wdata = mem_rdata;
                    idx_next      = idx_dec;
                    state_next    = S_ADD_RD;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    stat_next  = ST_ADDED;
                    state_next = S_RESP;
                end
            end
            S_RM_RD: begin
                if (idx_reg == count_reg) begin
                    stat_next  = ST_NOTFOUND;
                    state_next = S_RESP;
                end else begin
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (rd_eq) begin
                    state_next = S_SH_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_RM_RD;
                end
            end
            // close the gap: pull each later entry down one slot
            S_SH_RD: begin
                mem_req.raddr = idx_inc[ADDR_W-1:0];
                if (idx_inc == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    stat_next  = ST_REMOVED;
                    state_next = S_RESP;
                end else begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
                idx_next      = idx_inc;
                state_next    = S_SH_RD;
            end
            S_LS_RD: begin
                state_next = S_LS_OUT;
            end
            S_LS_OUT: begin
                res_valid  = 1'b1;
                res.status = ST_LISTED;
                res.entry  = ENTRY_W'(mem_rdata);
                res.last   = idx_inc == count_reg;
                if (take) begin
                    idx_next   = idx_inc;
                    state_next = res.last ? S_IDLE : S_LS_RD;
                end
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> idx_reg < CNT_W'(DEPTH) && idx_reg <= count_reg)
        else $error("store write outside the filled region");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SH_RD && idx_inc == count_reg)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not decrement count");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && res.last) |=> state_reg == S_IDLE)
        else $error("final result did not end the item");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd_ready)
        else $error("ready while an item is in progress");

endmodule
